FILE: hdl/assert_macros.svh
// assertion macros for the rtl, included by facl_seq
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked only outside reset
`define FACL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define FACL_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FACL_ASSERT(lbl, prop, msg)
`define FACL_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: hdl/facl_pkg.sv
// shared constants, types and helpers of the lfu cache
`default_nettype none

package facl_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int ADDR_W  = 32;
	localparam int TAG_W   = 30;
	localparam int WORD_W  = 32;
	localparam int CNT_W   = 16;
	localparam int USED_W  = 4;
	localparam int TOTAL_W = 32;

	localparam logic [CNT_W-1:0] VICTIM_LIMIT = CNT_W'(10000);
	localparam logic [CNT_W-1:0] COUNT_MAX    = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] COUNT_FILL   = CNT_W'(1);

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [TAG_W-1:0]   tag_t;
	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [TOTAL_W-1:0] total_t;

	// one entry as seen at the read port
	typedef struct packed {
		logic  valid;
		tag_t  tag;
		word_t word;
		cnt_t  count;
	} facl_rd_t;

	// one write: count always, tag and word too on a refill
	typedef struct packed {
		logic  en;
		logic  fill;
		idx_t  idx;
		tag_t  tag;
		word_t word;
		cnt_t  count;
	} facl_wr_t;

	// low bits of an entry index as reported on the result
	function automatic logic [USED_W-1:0] used_bits(input idx_t idx);
		logic [IDX_W+USED_W-1:0] ext;
		ext = (IDX_W+USED_W)'(idx);
		return ext[USED_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: hdl/facl_if.sv
// request and response channel interfaces
`default_nettype none

interface facl_req_if import facl_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ADDR_W-1:0]   address;
	word_t               fill_word;

	modport source (output valid, output address, output fill_word, input ready);
	modport sink   (input valid, input address, input fill_word, output ready);
endinterface

interface facl_rsp_if import facl_pkg::*; ();
	logic                valid;
	logic                ready;
	word_t               read_word;
	logic                was_hit;
	logic [USED_W-1:0]   entry_used;
	total_t              reference_total;
	total_t              hit_total;
	total_t              miss_total;

	modport source (
		output valid, output read_word, output was_hit, output entry_used,
		output reference_total, output hit_total, output miss_total,
		input ready
	);
	modport sink (
		input valid, input read_word, input was_hit, input entry_used,
		input reference_total, input hit_total, input miss_total,
		output ready
	);
endinterface

`default_nettype wire

FILE: hdl/facl_store.sv
// entry storage: valid bits, use counts, tags and words
`default_nettype none

module facl_store import facl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  idx_t     rd_idx,
	output facl_rd_t rd,
	input  facl_wr_t wr
);

	logic  valid_q [ENTRIES];
	cnt_t  count_q [ENTRIES];
	tag_t  tag_q   [ENTRIES];
	word_t word_q  [ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				count_q[i] <= '0;
			end
		end else if (wr.en) begin
			count_q[wr.idx] <= wr.count;
			if (wr.fill) begin
				valid_q[wr.idx] <= 1'b1;
			end
		end
	end

	// payload, meaningful only once the entry is valid
	always_ff @(posedge clk) begin
		if (wr.en && wr.fill) begin
			tag_q[wr.idx]  <= wr.tag;
			word_q[wr.idx] <= wr.word;
		end
	end

	always_comb begin
		rd.valid = valid_q[rd_idx];
		rd.tag   = tag_q[rd_idx];
		rd.word  = word_q[rd_idx];
		rd.count = count_q[rd_idx];
	end

endmodule

`default_nettype wire

FILE: hdl/facl_seq.sv
// scan sequencer with the shared tag and count compare, stats and result register
`default_nettype none

`include "assert_macros.svh"

module facl_seq import facl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	facl_req_if.sink   req,
	facl_rsp_if.source rsp,
	output idx_t       rd_idx,
	input  facl_rd_t   rd,
	output facl_wr_t   wr
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_UPDATE = 2'd2;

	localparam idx_t LAST_IDX = IDX_W'(ENTRIES - 1);

	logic [1:0] state_q;
	idx_t       scan_idx_q;
	tag_t       tag_q;
	word_t      fill_q;
	logic       hit_q;
	idx_t       hit_idx_q;
	word_t      hit_word_q;
	cnt_t       hit_cnt_q;
	cnt_t       least_q;
	idx_t       victim_q;

	total_t     ref_cnt_q;
	total_t     hit_cnt_tot_q;
	total_t     miss_cnt_q;

	logic              out_valid_q;
	word_t             read_word_q;
	logic              was_hit_q;
	logic [USED_W-1:0] entry_used_q;
	total_t            ref_tot_q;
	total_t            hit_tot_q;
	total_t            miss_tot_q;

	logic   req_fire;
	logic   out_free;
	logic   finish;
	logic   tag_eq;
	logic   cnt_lt;
	idx_t   sel_idx;
	total_t ref_next;
	total_t hit_next;
	total_t miss_next;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign finish    = (state_q == ST_UPDATE) && out_free;

	// the one compare unit, stepped across the entries
	assign rd_idx = scan_idx_q;
	assign tag_eq = rd.valid && (rd.tag == tag_q);
	assign cnt_lt = rd.count < least_q;

	assign sel_idx   = hit_q ? hit_idx_q : victim_q;
	assign ref_next  = ref_cnt_q + TOTAL_W'(1);
	assign hit_next  = hit_cnt_tot_q + TOTAL_W'(hit_q);
	assign miss_next = miss_cnt_q + TOTAL_W'(!hit_q);

	always_comb begin
		wr.en    = finish;
		wr.fill  = !hit_q;
		wr.idx   = sel_idx;
		wr.tag   = tag_q;
		wr.word  = fill_q;
		if (hit_q) begin
			wr.count = (hit_cnt_q == COUNT_MAX) ? hit_cnt_q : hit_cnt_q + CNT_W'(1);
		end else begin
			wr.count = COUNT_FILL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			scan_idx_q    <= '0;
			hit_q         <= 1'b0;
			ref_cnt_q     <= '0;
			hit_cnt_tot_q <= '0;
			miss_cnt_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						scan_idx_q <= '0;
						hit_q      <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!hit_q && tag_eq) begin
						hit_q <= 1'b1;
					end
					if (scan_idx_q == LAST_IDX) begin
						state_q <= ST_UPDATE;
					end else begin
						scan_idx_q <= scan_idx_q + IDX_W'(1);
					end
				end
				ST_UPDATE: begin
					if (out_free) begin
						ref_cnt_q     <= ref_next;
						hit_cnt_tot_q <= hit_next;
						miss_cnt_q    <= miss_next;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request payload and scan bookkeeping
	always_ff @(posedge clk) begin
		if (req_fire) begin
			tag_q    <= req.address[ADDR_W-1:ADDR_W-TAG_W];
			fill_q   <= req.fill_word;
			least_q  <= VICTIM_LIMIT;
			victim_q <= '0;
		end else if (state_q == ST_SCAN) begin
			if (!hit_q && tag_eq) begin
				hit_idx_q  <= scan_idx_q;
				hit_word_q <= rd.word;
				hit_cnt_q  <= rd.count;
			end
			if (cnt_lt) begin
				least_q  <= rd.count;
				victim_q <= scan_idx_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			read_word_q  <= hit_q ? hit_word_q : fill_q;
			was_hit_q    <= hit_q;
			entry_used_q <= used_bits(sel_idx);
			ref_tot_q    <= ref_next;
			hit_tot_q    <= hit_next;
			miss_tot_q   <= miss_next;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.read_word       = read_word_q;
	assign rsp.was_hit         = was_hit_q;
	assign rsp.entry_used      = entry_used_q;
	assign rsp.reference_total = ref_tot_q;
	assign rsp.hit_total       = hit_tot_q;
	assign rsp.miss_total      = miss_tot_q;

	`FACL_ASSERT_ALWAYS(a_totals_sum, ref_cnt_q == hit_cnt_tot_q + miss_cnt_q, "reference total is not hits plus misses")
	`FACL_ASSERT(a_scan_start, req_fire |=> (state_q == ST_SCAN) && (scan_idx_q == '0), "scan did not start at entry zero")
	`FACL_ASSERT(a_scan_step, (state_q == ST_SCAN) && (scan_idx_q != LAST_IDX) |=> (state_q == ST_SCAN) && (scan_idx_q == $past(scan_idx_q) + IDX_W'(1)), "scan skipped or stalled an entry")
	`FACL_ASSERT(a_result_src, $rose(out_valid_q) |-> $past(state_q) == ST_UPDATE, "result raised outside the update step")

endmodule

`default_nettype wire

FILE: hdl/fully_assoc_cache_lfu_unit.sv
// Fully associative cache with least-frequently-used replacement, 16 entries.
// Each request is accepted, then the tag and count compare steps through the
// entries in turn, then an update step writes the entry and registers the result.
// The entry scan through the single compare unit sets the rate; a waiting result
// does not hold off the next request until its update cycle.
// Reset clears all valid bits, use counts and the three totals at once.
`default_nettype none

module fully_assoc_cache_lfu_unit import facl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	facl_req_if.sink   req,
	facl_rsp_if.source rsp
);

	idx_t     rd_idx;
	facl_rd_t rd;
	facl_wr_t wr;

	facl_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (rd_idx),
		.rd     (rd),
		.wr     (wr)
	);

	facl_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.rd_idx (rd_idx),
		.rd     (rd),
		.wr     (wr)
	);

endmodule

`default_nettype wire
